[rtl/srbp_pkg.sv]
// Package for the signed Rice bit packer.
// Holds shared constants and the bit request type between sequencer and packer.
// Depends on nothing.
package srbp_pkg;

    // Default sample width and fixed field widths.
    localparam int DELTA_BITS_DEF = 13;
    localparam int RICE_K_W       = 4;
    localparam int BYTE_W         = 8;
    localparam int VBITS_W        = 4;
    localparam int CNT_W          = 3;

    // Rice parameter lower limit and reset value.
    localparam logic [RICE_K_W-1:0] RICE_K_MIN = 4'd4;
    localparam logic [RICE_K_W-1:0] RICE_K_RST = 4'd4;

    // One code bit handed from the sequencer to the packer.
    typedef struct packed {
        logic vld;        // a bit is offered this cycle
        logic value;      // the code bit
        logic code_end;   // last bit of the current code
        logic flush;      // block ends after this code
    } t_bit_req;

endpackage

[rtl/srbp_in_if.sv]
// Input and output channel interfaces of the signed Rice bit packer.
// Each carries valid, ready and the payload. Depends on nothing.
interface srbp_in_if #(
    parameter int DELTA_BITS = 13
);
    logic                         valid;
    logic                         ready;
    logic signed [DELTA_BITS-1:0] delta;
    logic                         end_of_block;

    modport source (output valid, delta, end_of_block, input ready);
    modport sink   (input valid, delta, end_of_block, output ready);
endinterface

interface srbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] valid_bits;
    logic       last;

    modport source (output valid, out_byte, valid_bits, last, input ready);
    modport sink   (input valid, out_byte, valid_bits, last, output ready);
endinterface

[rtl/srbp_code_seq.sv]
// Code sequencer: takes one delta request and walks its Rice code one bit a cycle while the packer takes bits.
// Depends on srbp_pkg and the input channel interface.
module srbp_code_seq
    import srbp_pkg::*;
#(
    parameter int DELTA_BITS = DELTA_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    srbp_in_if.sink             i_in,
    input  logic [RICE_K_W-1:0] i_rice_k,
    output t_bit_req            o_req,
    input  logic                i_bit_ok
);
    localparam int MAG_W = DELTA_BITS - 1;
    localparam int Q_W   = MAG_W - 4;
    localparam logic [DELTA_BITS-1:0] MAX_MAG = DELTA_BITS'((1 << MAG_W) - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAD,
        S_SIGN,
        S_UNARY,
        S_STOP,
        S_REM
    } t_state;

    t_state               r_state;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_neg;
    logic                 r_eob;
    logic [Q_W-1:0]       r_q;
    logic [RICE_K_W-1:0]  r_idx;

    logic                  accept;
    logic                  neg_in;
    logic [DELTA_BITS-1:0] mag_full;
    logic [MAG_W-1:0]      mag_in;
    logic [RICE_K_W-1:0]   k_eff;
    logic [MAG_W-1:0]      q_full;
    logic [MAG_W-1:0]      rem_shift;

    // Magnitude with saturation of the most negative pattern, and the quotient.
    always_comb begin
        neg_in   = i_in.delta[DELTA_BITS-1];
        mag_full = neg_in ? DELTA_BITS'(-i_in.delta) : DELTA_BITS'(i_in.delta);
        if (mag_full > MAX_MAG) begin
            mag_full = MAX_MAG;
        end
        mag_in = mag_full[MAG_W-1:0];
        k_eff  = (i_rice_k < RICE_K_MIN) ? RICE_K_MIN : i_rice_k;
        q_full = mag_in >> k_eff;
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign rem_shift  = r_mag >> (r_idx - RICE_K_W'(1));

    // Bit offered to the packer in each state.
    always_comb begin
        o_req          = '0;
        o_req.flush    = r_eob;
        o_req.vld      = (r_state != S_IDLE);
        case (r_state)
            S_LEAD: begin
                o_req.value    = (r_mag != '0);
                o_req.code_end = (r_mag == '0);
            end
            S_SIGN:  o_req.value = r_neg;
            S_UNARY: o_req.value = 1'b1;
            S_STOP:  o_req.value = 1'b0;
            S_REM: begin
                o_req.value    = rem_shift[0];
                o_req.code_end = (r_idx == RICE_K_W'(1));
            end
            default: o_req.vld = 1'b0;
        endcase
    end

    // State and item registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eob   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LEAD;
                        r_mag   <= mag_in;
                        r_neg   <= neg_in;
                        r_eob   <= i_in.end_of_block;
                        r_q     <= q_full[Q_W-1:0];
                        r_idx   <= k_eff;
                    end
                end
                S_LEAD: begin
                    if (i_bit_ok) begin
                        r_state <= (r_mag == '0) ? S_IDLE : S_SIGN;
                    end
                end
                S_SIGN: begin
                    if (i_bit_ok) begin
                        r_state <= (r_q == '0) ? S_STOP : S_UNARY;
                    end
                end
                S_UNARY: begin
                    if (i_bit_ok) begin
                        r_q <= r_q - Q_W'(1);
                        if (r_q == Q_W'(1)) begin
                            r_state <= S_STOP;
                        end
                    end
                end
                S_STOP: begin
                    if (i_bit_ok) begin
                        r_state <= S_REM;
                    end
                end
                S_REM: begin
                    if (i_bit_ok) begin
                        r_idx <= r_idx - RICE_K_W'(1);
                        if (r_idx == RICE_K_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // An accepted request always starts with the leading bit.
    a_accept_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_LEAD)
        else $error("sequencer did not start a code after a request");

    // The remainder walk never runs with a zero bit index.
    a_rem_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REM |-> r_idx != '0)
        else $error("remainder index underflow");

endmodule

[rtl/srbp_bit_packer.sv]
// Bit packer: collects code bits MSB first into bytes and holds the output register.
// Depends on srbp_pkg and the output channel interface.
module srbp_bit_packer
    import srbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bit_req    i_req,
    output logic        o_bit_ok,
    srbp_out_if.source  o_out
);
    logic [BYTE_W-1:0]  r_bits;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_vld;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [VBITS_W-1:0] r_out_vbits;
    logic               r_out_last;

    logic [BYTE_W-1:0]  n_bits;
    logic [VBITS_W-1:0] n_count;
    logic               take;
    logic               full;
    logic               flush_now;

    // A bit is taken only when the output slot is free or draining.
    assign o_bit_ok  = !r_out_vld || o_out.ready;
    assign take      = i_req.vld && o_bit_ok;

    // Insert the bit at the next free position.
    always_comb begin
        n_bits    = r_bits | (BYTE_W'(i_req.value) << (CNT_W'(BYTE_W - 1) - r_cnt));
        n_count   = VBITS_W'(r_cnt) + VBITS_W'(1);
        full      = (r_cnt == CNT_W'(BYTE_W - 1));
        flush_now = i_req.code_end && i_req.flush;
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.valid_bits = r_out_vbits;
    assign o_out.last       = r_out_last;

    // Pending byte and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else if (take && (full || flush_now)) begin
            // A finished byte loads the output slot, which is free or draining now.
            r_out_vld   <= 1'b1;
            r_out_byte  <= n_bits;
            r_out_vbits <= n_count;
            r_out_last  <= flush_now;
            r_bits      <= '0;
            r_cnt       <= '0;
        end else begin
            if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (take) begin
                r_bits <= n_bits;
                r_cnt  <= n_count[CNT_W-1:0];
            end
        end
    end

    // A shown byte always carries between one and eight valid bits.
    a_vbits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_vbits != '0 && r_out_vbits <= VBITS_W'(BYTE_W)))
        else $error("valid bit count out of range");

    // Only the last byte of a block may be partial.
    a_partial_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> r_out_vbits == VBITS_W'(BYTE_W))
        else $error("partial byte without end of block");

    // The end of a flushed code leaves nothing pending.
    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && flush_now) |=> (r_cnt == '0 && r_bits == '0))
        else $error("pending bits left after flush");

endmodule

[rtl/signed_rice_bit_packer_unit.sv]
// Signed Rice bit packer, top level: configuration register, sequencer and packer.
// A request is taken while the sequencer is idle; its code bits then follow one per cycle,
// a zero delta giving one code bit and other deltas 3 + (|delta| >> k) + k code bits (k at least 4),
// while the output register takes bits; a byte held in the output register stalls the bits.
// Throughput is at most one code bit and one byte per cycle.
// Reset (synchronous, active low) clears pending bits, the output slot, and sets k to 4.
module signed_rice_bit_packer_unit
    import srbp_pkg::*;
#(
    parameter int DELTA_BITS = DELTA_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    srbp_in_if.sink             i_in,
    srbp_out_if.source          o_out,
    input  logic                i_cfg_we,
    input  logic [RICE_K_W-1:0] i_cfg_wdata
);
    logic [RICE_K_W-1:0] r_rice_k;
    t_bit_req            bit_req;
    logic                bit_ok;

    // Rice parameter register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rice_k <= RICE_K_RST;
        end else if (i_cfg_we) begin
            r_rice_k <= i_cfg_wdata;
        end
    end

    // Code bit sequencer.
    srbp_code_seq #(
        .DELTA_BITS (DELTA_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_rice_k (r_rice_k),
        .o_req    (bit_req),
        .i_bit_ok (bit_ok)
    );

    // Byte packer with output register.
    srbp_bit_packer u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (bit_req),
        .o_bit_ok (bit_ok),
        .o_out    (o_out)
    );

endmodule
